[rtl/masked_route_table_lookup_assert.svh]
// ----------------------------------------------------------------------------
// masked_route_table_lookup_assert.svh
// Assertion macros for the route table lookup block.
// ----------------------------------------------------------------------------
`ifndef MASKED_ROUTE_TABLE_LOOKUP_ASSERT_SVH
`define MASKED_ROUTE_TABLE_LOOKUP_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define MRTL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define MRTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MRTL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MRTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/mrtl_pkg.sv]
// ----------------------------------------------------------------------------
// mrtl_pkg
// Shared types and constants of the masked route table lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrtl_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int ROUTE_CAPACITY = TABLE_SLOTS - 1;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int RAM_AW = (ROUTE_CAPACITY > 1) ? $clog2(ROUTE_CAPACITY) : 1;

  localparam logic [IDX_W-1:0] ROUTE_CAP = IDX_W'(ROUTE_CAPACITY);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MATCHED = 2'd2;
  localparam logic [1:0] ST_DEFAULT = 2'd3;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
  } route_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    route_t            wdata;
  } ram_req_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] fill;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/mrtl_ram.sv]
// ----------------------------------------------------------------------------
// mrtl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/mrtl_cmp.sv]
// ----------------------------------------------------------------------------
// mrtl_cmp
// Shared masked comparator: address against one stored route.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrtl_cmp (
  input  wire logic [31:0] key,
  input  wire logic [31:0] dest,
  input  wire logic [31:0] mask,
  output logic             hit
);

  assign hit = ((key ^ dest) & mask) == 32'd0;

endmodule

`default_nettype wire

[rtl/mrtl_ctrl.sv]
// ----------------------------------------------------------------------------
// mrtl_ctrl
// Sequencer: stores routes, walks the table for lookups, holds the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrtl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 operation,
  input  wire logic [31:0]          address,
  input  wire logic [31:0]          gateway_in,
  input  wire logic [31:0]          mask,
  input  wire logic [31:0]          default_gateway,
  output mrtl_pkg::ram_req_t        ram_req,
  input  wire mrtl_pkg::route_t     ram_rdata,
  input  wire logic                 hit,
  output logic [31:0]               key,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [31:0]               gateway_out,
  output logic [1:0]                status,
  output mrtl_pkg::ctrl_stat_t      ctrl_stat
);

  import mrtl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pend;
  logic [31:0]      res_gw;
  logic [1:0]       res_status;
  logic             issue;
  logic             rsp_free;
  logic             add_ok;

  assign req_stall = (state != S_IDLE);
  assign issue     = (rd_idx < count);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign add_ok    = (count < ROUTE_CAP);

  assign ram_req.we    = (state == S_IDLE) && req_valid && (operation == OP_ADD) && add_ok;
  assign ram_req.addr  = ram_req.we ? RAM_AW'(count) : RAM_AW'(rd_idx);
  assign ram_req.wdata = '{dest: address, mask: mask, gateway: gateway_in};

  assign ctrl_stat.busy = req_stall;
  assign ctrl_stat.fill = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            key     <= address;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            if (operation == OP_ADD) begin
              res_gw <= 32'd0;
              if (add_ok) begin
                count      <= count + IDX_W'(1);
                res_status <= ST_ADDED;
              end else begin
                res_status <= ST_FULL;
              end
              state <= S_DONE;
            end else if (count == '0) begin
              res_gw     <= default_gateway;
              res_status <= ST_DEFAULT;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
          if (rd_pend && hit) begin
            res_gw     <= ram_rdata.gateway;
            res_status <= ST_MATCHED;
            state      <= S_DONE;
          end else if (rd_pend && !issue) begin
            res_gw     <= default_gateway;
            res_status <= ST_DEFAULT;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            gateway_out <= res_gw;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/masked_route_table_lookup.sv]
// ----------------------------------------------------------------------------
// masked_route_table_lookup
// First-match masked IPv4 route table with a configurable default gateway.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_stall  operation, address, gateway_in, mask
//   rsp      out        rsp_valid/rsp_stall  gateway_out, status
//   cfg      in         cfg_valid/cfg_ready  cfg_data (default gateway)
//
// An add passes through S_DONE to the response register. During a lookup,
// one RAM read per cycle feeds the single masked comparator, and the walk
// ends at the first match or after the last stored route.
// One transaction in flight; req_stall is high until the response is loaded.
// A stalled response holds while the next request is taken.
// Synchronous reset empties the table and clears the default gateway.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "masked_route_table_lookup_assert.svh"

module masked_route_table_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        operation,
  input  wire logic [31:0] address,
  input  wire logic [31:0] gateway_in,
  input  wire logic [31:0] mask,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [31:0]      gateway_out,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  import mrtl_pkg::*;

  logic [31:0] default_gateway;
  ram_req_t    ram_req;
  route_t      ram_rdata;
  logic        hit;
  logic [31:0] key;
  ctrl_stat_t  ctrl_stat;
  logic        req_fire;
  logic        full_rsp;
  logic        at_cap;
  logic        full_add;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_gateway <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      default_gateway <= cfg_data;
    end
  end

  mrtl_ram #(
    .WIDTH($bits(route_t)),
    .DEPTH(ROUTE_CAPACITY)
  ) u_route_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .addr (ram_req.addr),
    .wdata(ram_req.wdata),
    .rdata(ram_rdata)
  );

  mrtl_cmp u_cmp (
    .key (key),
    .dest(ram_rdata.dest),
    .mask(ram_rdata.mask),
    .hit (hit)
  );

  mrtl_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .operation      (operation),
    .address        (address),
    .gateway_in     (gateway_in),
    .mask           (mask),
    .default_gateway(default_gateway),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata),
    .hit            (hit),
    .key            (key),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .gateway_out    (gateway_out),
    .status         (status),
    .ctrl_stat      (ctrl_stat)
  );

  assign req_fire = req_valid && !req_stall;
  assign full_rsp = rsp_valid && (status == ST_FULL);
  assign at_cap   = (ctrl_stat.fill == ROUTE_CAP);
  assign full_add = req_fire && (operation == OP_ADD) && at_cap;

  `MRTL_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_fire, ctrl_stat.busy, "accept not busy")
  `MRTL_ASSERT_IMP(a_full_at_capacity, clk, rst, full_rsp, at_cap, "full status below capacity")
  `MRTL_ASSERT_NEXT(a_full_add_stable, clk, rst, full_add, $stable(ctrl_stat.fill), "fill moved")

endmodule

`default_nettype wire

[test/masked_route_table_lookup_tb.sv]
// ----------------------------------------------------------------------------
// masked_route_table_lookup_tb
// Self-checking bench for the first-match masked route table.
//
// A queue-fed driver offers add and lookup transactions with random gaps. A
// monitor stalls responses at random, once for a long stretch, and checks
// each response against a running prediction of the table. The default
// gateway is rewritten between phases while the block is idle. The last slot
// is taken by a catch-all route, and further adds check the full status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_route_table_lookup_tb;
  import mrtl_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int DRAIN_PAUSE = 80;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [31:0] gw;
    logic [31:0] msk;
  } route_req_t;

  typedef struct packed {
    logic [31:0] gateway;
    logic [1:0]  status;
  } route_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        operation = 1'b0;
  logic [31:0] address = '0;
  logic [31:0] gateway_in = '0;
  logic [31:0] mask = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] gateway_out;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // predicted table contents
  logic [31:0] tbl_dest [ROUTE_CAPACITY];
  logic [31:0] tbl_mask [ROUTE_CAPACITY];
  logic [31:0] tbl_gw   [ROUTE_CAPACITY];
  int          stored_routes = 0;
  logic [31:0] default_gw = '0;

  // routes issued so far, used to aim lookups
  logic [31:0] plan_dest [ROUTE_CAPACITY];
  logic [31:0] plan_mask [ROUTE_CAPACITY];
  int          plan_count = 0;

  route_req_t    pending_reqs[$];
  route_result_t expected_results[$];

  int fail_count = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_stall_left = 0;
  int rx_calm = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int responses_seen = 0;
  route_result_t want;
  route_req_t    next_req;

  masked_route_table_lookup i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .address    (address),
    .gateway_in (gateway_in),
    .mask       (mask),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .gateway_out(gateway_out),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 880) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic route_result_t predict_route(logic op, logic [31:0] addr,
                                                  logic [31:0] gw, logic [31:0] msk);
    route_result_t r;
    r.gateway = '0;
    if (op == OP_ADD) begin
      if (stored_routes >= ROUTE_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        tbl_dest[stored_routes] = addr;
        tbl_mask[stored_routes] = msk;
        tbl_gw[stored_routes] = gw;
        stored_routes++;
        r.status = ST_ADDED;
      end
    end else begin
      r.status = ST_DEFAULT;
      r.gateway = default_gw;
      for (int k = 0; k < stored_routes; k++) begin
        if (((addr ^ tbl_dest[k]) & tbl_mask[k]) == 32'h0) begin
          r.gateway = tbl_gw[k];
          r.status = ST_MATCHED;
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] random_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 75) return 32'hFFFF_FFFF << $urandom_range(1, 24);
    return $urandom | $urandom | (32'h1 << $urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] lookup_address();
    int          r;
    int          k;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (plan_count == 0 || r < 25) return $urandom;
    k = $urandom_range(0, plan_count - 1);
    a = (plan_dest[k] & plan_mask[k]) | ($urandom & ~plan_mask[k]);
    if (r < 35) a ^= 32'h1 << $urandom_range(0, 31);
    return a;
  endfunction

  task automatic push_item(logic op, logic [31:0] addr, logic [31:0] gw, logic [31:0] msk);
    if (op == OP_ADD && plan_count < ROUTE_CAPACITY) begin
      plan_dest[plan_count] = addr;
      plan_mask[plan_count] = msk;
      plan_count++;
    end
    pending_reqs.push_back('{op: op, addr: addr, gw: gw, msk: msk});
  endtask

  task automatic push_lookup();
    push_item(OP_LOOKUP, lookup_address(), $urandom, $urandom);
  endtask

  task automatic push_random_route();
    push_item(OP_ADD, $urandom, $urandom, random_mask());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_default_gateway(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    default_gw = value;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_results.push_back(predict_route(operation, address, gateway_in, mask));
        tx_gap = draw_gap(tx_calm);
      end
      if (req_valid && req_stall) begin
        // hold the stalled transaction
      end else if (tx_gap > 0) begin
        tx_gap--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        req_valid <= 1'b1;
        operation <= next_req.op;
        address <= next_req.addr;
        gateway_in <= next_req.gw;
        mask <= next_req.msk;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected response: gateway_out %h status %0d", gateway_out, status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (gateway_out !== want.gateway) begin
            $error("gateway_out: expected %h, actual %h", want.gateway, gateway_out);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (!held_once && responses_seen >= 150) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        rx_stall_left = draw_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_gw [4];
    phase_gw = '{32'h0000_0000, 32'h8000_0000, $urandom, 32'h0000_0001};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, reset default gateway; unused fields driven to extremes
    @(negedge clk);
    push_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    write_default_gateway(32'hFFFF_FFFF);
    @(negedge clk);
    push_item(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0);
    push_item(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_ADD, 32'h0A00_0000, 32'h0A00_00FE, 32'hFF00_0000);
    // more specific, but shadowed by the /8 added first
    push_item(OP_ADD, 32'h0A01_0000, 32'h0A01_00FE, 32'hFFFF_0000);
    // non-contiguous mask
    push_item(OP_ADD, 32'h0000_0001, 32'h5A5A_5A5A, 32'h8000_0001);
    push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0);
    push_item(OP_LOOKUP, 32'h0AFF_FFFF, 32'h0, 32'h0);
    push_item(OP_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0);
    push_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0);
    push_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0);
    wait_drained();

    // table fills up gradually
    for (int ph = 0; ph < 4; ph++) begin
      write_default_gateway(phase_gw[ph]);
      @(negedge clk);
      for (int n = 0; n < 200; n++) begin
        if (plan_count < ROUTE_CAPACITY - 1 && $urandom_range(0, 99) < 9) push_random_route();
        else push_lookup();
      end
      wait_drained();
    end

    // top up to one free slot, then lookups only
    write_default_gateway($urandom);
    @(negedge clk);
    while (plan_count < ROUTE_CAPACITY - 1) push_random_route();
    for (int n = 0; n < 300; n++) push_lookup();
    wait_drained();

    // catch-all route in the last slot, then adds hit the full table
    write_default_gateway($urandom);
    @(negedge clk);
    push_item(OP_ADD, $urandom, $urandom, 32'h0000_0000);
    for (int n = 0; n < 600; n++) begin
      if ($urandom_range(0, 99) < 20) push_item(OP_ADD, $urandom, $urandom, $urandom);
      else push_lookup();
    end
    wait_drained();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[masked_route_table_lookup.f]
+incdir+rtl
rtl/mrtl_pkg.sv
rtl/mrtl_ram.sv
rtl/mrtl_cmp.sv
rtl/mrtl_ctrl.sv
rtl/masked_route_table_lookup.sv
test/masked_route_table_lookup_tb.sv
